// ===== design/sha256_message_digest_defines.svh =====
// assertion macros for the sha256 message digest checker
// no dependencies; included by the checker file only
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SHA256MD_ASSERT_NOW(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("sha256md check failed");

// condition that must hold in the cycle after the trigger
`define SHA256MD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sha256md check failed");

`endif

// ===== design/sha256md_pkg.sv =====
// shared types, constants and round functions of the sha256 digest block
// no dependencies
package sha256md_pkg;

  typedef logic [7:0][31:0] chain_t;

  // commands from the sequencer to the compression unit
  typedef struct packed {
    logic       shift_en;
    logic [7:0] shift_byte;
    logic       start;
    logic       init;
  } blk_ctrl_t;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] PAD_END   = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [1:0] IDX_LAST  = 2'd3;

  localparam chain_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== design/sha256md_if.sv =====
// valid/ready channel interfaces for byte input and digest word output
// no dependencies
interface sha256md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_item;

  modport source (output valid, data_byte, byte_valid, last_item, input ready);
  modport sink   (input valid, data_byte, byte_valid, last_item, output ready);
endinterface

interface sha256md_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sha256_message_digest.sv =====
// top level: byte intake, padding sequencer and digest word output
// depends on sha256md_pkg, sha256md_if and sha256md_block
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   data_byte, byte_valid, last_item
//   out_o    out  valid/ready   digest_word, word_index, last_word
//
// a byte without a full block or last is taken while idle; the 64th byte of a block
// starts the compression unit (64 rounds, one final add)
// a last item adds padding through the byte window plus one
// or two compressions, then the four digest words wait on out_o.ready
// in_i.ready is low during a compression, during padding and until the fourth
// digest word is taken; reset restores the initial chain and clears the byte count
module sha256_message_digest (
  input logic            clk_i,
  input logic            rst_ni,
  sha256md_in_if.sink    in_i,
  sha256md_out_if.source out_o
);
  import sha256md_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_COMP   = 6'b000010,
    ST_PAD80  = 6'b000100,
    ST_PADZ   = 6'b001000,
    ST_PADLEN = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic        pad_q, pad_d;
  logic        len_done_q, len_done_d;
  logic        last_pend_q, last_pend_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;

  blk_ctrl_t   ctrl;
  logic        blk_done;
  chain_t      chain;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic        in_acc, out_acc;

  sha256md_block u_block (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .done_o  (blk_done),
    .chain_o (chain)
  );

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_o.valid & out_o.ready;

  // length bytes go out big-endian while the fill runs from 56 to 63
  assign len_bits = {total_q, 3'b000};
  assign len_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    total_d     = total_q;
    pad_d       = pad_q;
    len_done_d  = len_done_q;
    last_pend_d = last_pend_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    ctrl        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.byte_valid) begin
            ctrl.shift_en   = 1'b1;
            ctrl.shift_byte = in_i.data_byte;
            fill_d          = fill_q + 6'd1;
            total_d         = total_q + 61'd1;
            if (fill_q == FILL_LAST) begin
              ctrl.start  = 1'b1;
              last_pend_d = in_i.last_item;
              state_d     = ST_COMP;
            end else if (in_i.last_item) begin
              state_d = ST_PAD80;
            end
          end else if (in_i.last_item) begin
            state_d = ST_PAD80;
          end
        end
      end
      ST_COMP: begin
        if (blk_done) begin
          if (len_done_q) begin
            out_valid_d = 1'b1;
            idx_d       = '0;
            state_d     = ST_OUT;
          end else if (pad_q) begin
            state_d = ST_PADZ;
          end else if (last_pend_q) begin
            state_d = ST_PAD80;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAD80: begin
        ctrl.shift_en   = 1'b1;
        ctrl.shift_byte = PAD_BYTE;
        fill_d          = fill_q + 6'd1;
        pad_d           = 1'b1;
        last_pend_d     = 1'b0;
        if (fill_q == FILL_LAST) begin
          ctrl.start = 1'b1;
          state_d    = ST_COMP;
        end else begin
          state_d = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (fill_q == PAD_END) begin
          state_d = ST_PADLEN;
        end else begin
          ctrl.shift_en   = 1'b1;
          ctrl.shift_byte = '0;
          fill_d          = fill_q + 6'd1;
          if (fill_q == FILL_LAST) begin
            ctrl.start = 1'b1;
            state_d    = ST_COMP;
          end
        end
      end
      ST_PADLEN: begin
        ctrl.shift_en   = 1'b1;
        ctrl.shift_byte = len_byte;
        fill_d          = fill_q + 6'd1;
        if (fill_q == FILL_LAST) begin
          ctrl.start = 1'b1;
          len_done_d = 1'b1;
          state_d    = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (idx_q == IDX_LAST) begin
            out_valid_d = 1'b0;
            idx_d       = '0;
            total_d     = '0;
            pad_d       = 1'b0;
            len_done_d  = 1'b0;
            ctrl.init   = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      pad_q       <= 1'b0;
      len_done_q  <= 1'b0;
      last_pend_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      pad_q       <= pad_d;
      len_done_q  <= len_done_d;
      last_pend_q <= last_pend_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == IDX_LAST);
  assign out_o.digest_word = {chain[{idx_q, 1'b0}], chain[{idx_q, 1'b1}]};

endmodule

// ===== design/sha256md_block.sv =====
// block window, message schedule and one-round-per-cycle compression unit
// depends on sha256md_pkg
module sha256md_block (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sha256md_pkg::blk_ctrl_t ctrl_i,
  output logic                    done_o,
  output sha256md_pkg::chain_t    chain_o
);
  import sha256md_pkg::*;

  logic [511:0] win_q, win_d;
  chain_t       h_q, v_q, v_d;
  logic [5:0]   rnd_q;
  logic         busy_q, fin_q;

  logic [31:0] w0, w1, w9, w14, w_new, t1, t2, ch, maj;

  // window word 0 is the oldest; bytes enter at the low end
  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];

  always_comb begin
    w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + bsig1(v_q[4]) + ch + K_TAB[rnd_q] + w0;
    t2    = bsig0(v_q[0]) + maj;

    v_d = v_q;
    if (ctrl_i.start) begin
      v_d = h_q;
    end else if (busy_q) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end

    win_d = win_q;
    if (busy_q) begin
      win_d = {win_q[479:0], w_new};
    end else if (ctrl_i.shift_en) begin
      win_d = {win_q[503:0], ctrl_i.shift_byte};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      h_q    <= H_INIT;
    end else begin
      fin_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == RND_LAST) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end else if (ctrl_i.init) begin
        h_q <= H_INIT;
      end
    end
  end

  assign done_o  = fin_q;
  assign chain_o = h_q;

endmodule

// ===== design/sha256md_checker.sv =====
// port-level checks on the sha256 digest block, bound to the top level
// depends on sha256_message_digest_defines.svh and sha256_message_digest
`include "sha256_message_digest_defines.svh"

module sha256md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_digest_word_i,
  input logic [1:0]  out_word_index_i,
  input logic        out_last_word_i
);

  logic out_acc;
  assign out_acc = out_valid_i & out_ready_i;

  // no new byte is taken while digest words are pending
  `SHA256MD_ASSERT_NOW(a_no_in_during_out, clk_i, rst_ni, !(in_ready_i && out_valid_i))

  `SHA256MD_ASSERT_NOW(a_last_flag, clk_i, rst_ni, !out_valid_i || (out_last_word_i == (out_word_index_i == 2'd3)))

  // digest words come in order, four per message
  `SHA256MD_ASSERT_NEXT(a_index_step, clk_i, rst_ni, out_acc && !out_last_word_i, out_valid_i && (out_word_index_i == $past(out_word_index_i) + 2'd1))

  `SHA256MD_ASSERT_NEXT(a_end_of_digest, clk_i, rst_ni, out_acc && out_last_word_i, !out_valid_i)

  `SHA256MD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_digest_word_i))

endmodule

bind sha256_message_digest sha256md_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_digest_word_i (out_o.digest_word),
  .out_word_index_i  (out_o.word_index),
  .out_last_word_i   (out_o.last_word)
);
